// File: src/kaat_pkg.sv
// ----------------------------------------------------------------------------
// kaat_pkg
// Shared types and command codes for the keyed accumulator with running
// argmax tracker.
// ----------------------------------------------------------------------------
package kaat_pkg;

	// Command codes carried on the command port.
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Control states of the add sequencer.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPD
	} state_t;

endpackage

// File: src/kaat_ram.sv
// ----------------------------------------------------------------------------
// kaat_ram
// Simple dual-port synchronous memory: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
module kaat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/keyed_accumulator_argmax_tracker_top.sv
// ----------------------------------------------------------------------------
// keyed_accumulator_argmax_tracker_top
// Key table with saturating per-key sums and a running best key.
// ----------------------------------------------------------------------------
// A query answer strobes for one cycle right after the query is accepted. Busy
// stays low for a query, so queries can be accepted every cycle while no add
// holds busy; the receiver cannot stall. An add holds busy while the key scan
// compares one stored entry per cycle: through the matching entry and then the
// sum update state, or through every stored entry when the key is new.
// Reset clears the count, best key, best sum and drop flag; memories are not cleared.
module keyed_accumulator_argmax_tracker_top #(
	parameter int ENTRIES  = 64,
	parameter int SUM_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] key,
	input  logic [31:0] amount,
	output logic        result_valid,
	output logic [31:0] best_key,
	output logic        has_data,
	output logic        overflowed
);

	localparam int ADDR_W = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);

	kaat_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    scan_idx_q;
	logic                cmp_valid_q;
	logic [ADDR_W-1:0]   cmp_idx_q;
	logic [ADDR_W-1:0]   hit_idx_q;
	logic [31:0]         key_q;
	logic [31:0]         amount_q;
	logic [31:0]         best_key_q;
	logic [SUM_BITS-1:0] best_sum_q;
	logic                drop_q;
	logic                result_valid_q;

	logic                accept;
	logic                issue;
	logic                hit;
	logic                miss;
	logic                room;
	logic                key_we;
	logic                sum_we;
	logic [ADDR_W-1:0]   sum_waddr;
	logic [SUM_BITS-1:0] sum_wdata;
	logic [31:0]         key_rd;
	logic [SUM_BITS-1:0] sum_rd;
	logic [SUM_BITS:0]   sum_ext;
	logic [SUM_BITS-1:0] upd_sum;
	logic [SUM_BITS-1:0] ins_sum;

	assign busy   = (state_q != kaat_pkg::S_IDLE);
	assign accept = start && !busy;
	assign issue  = (scan_idx_q < count_q);
	assign hit    = cmp_valid_q && (key_rd == key_q);
	assign room   = (count_q < CNT_W'(ENTRIES));

	// Saturating add of the amount onto the stored sum.
	assign sum_ext = {1'b0, sum_rd} + (SUM_BITS + 1)'(amount_q);
	assign upd_sum = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
	assign ins_sum = SUM_BITS'(amount_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kaat_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		miss      = 1'b0;
		key_we    = 1'b0;
		sum_we    = 1'b0;
		sum_waddr = hit_idx_q;
		sum_wdata = upd_sum;
		case (state_q)
			kaat_pkg::S_IDLE: begin
				if (accept && command == kaat_pkg::CMD_ADD) begin
					state_d = kaat_pkg::S_SCAN;
				end
			end
			kaat_pkg::S_SCAN: begin
				if (hit) begin
					state_d = kaat_pkg::S_UPD;
				end else if (!issue && !cmp_valid_q) begin
					// Whole table compared without a match.
					miss      = 1'b1;
					key_we    = room;
					sum_we    = room;
					sum_waddr = count_q[ADDR_W-1:0];
					sum_wdata = ins_sum;
					state_d   = kaat_pkg::S_IDLE;
				end
			end
			kaat_pkg::S_UPD: begin
				sum_we  = 1'b1;
				state_d = kaat_pkg::S_IDLE;
			end
			default: begin
				state_d = kaat_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			scan_idx_q     <= '0;
			cmp_valid_q    <= 1'b0;
			best_key_q     <= '0;
			best_sum_q     <= '0;
			drop_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= accept && (command == kaat_pkg::CMD_QUERY);
			if (accept) begin
				scan_idx_q  <= '0;
				cmp_valid_q <= 1'b0;
			end else if (state_q == kaat_pkg::S_SCAN) begin
				cmp_valid_q <= issue && !hit;
				if (issue && !hit) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
			end
			if (miss) begin
				if (room) begin
					count_q <= count_q + CNT_W'(1);
					if (ins_sum > best_sum_q) begin
						best_sum_q <= ins_sum;
						best_key_q <= key_q;
					end
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (state_q == kaat_pkg::S_UPD && upd_sum > best_sum_q) begin
				best_sum_q <= upd_sum;
				best_key_q <= key_q;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= key;
			amount_q <= amount;
		end
		cmp_idx_q <= scan_idx_q[ADDR_W-1:0];
		if (hit) begin
			hit_idx_q <= cmp_idx_q;
		end
	end

	kaat_ram #(
		.WIDTH (32),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (key_q),
		.raddr (scan_idx_q[ADDR_W-1:0]),
		.rdata (key_rd)
	);

	// The sum read is issued on the hit beat, so its data is ready in S_UPD.
	kaat_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (ENTRIES)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (cmp_idx_q),
		.rdata (sum_rd)
	);

	assign result_valid = result_valid_q;
	assign best_key     = best_key_q;
	assign has_data     = (count_q != '0);
	assign overflowed   = drop_q;

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy && command == kaat_pkg::CMD_QUERY))
		else $error("result strobe without an accepted query");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |-> (count_q < CNT_W'(ENTRIES)) && miss)
		else $error("key written without a free entry");

	a_drop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflowed |=> overflowed)
		else $error("drop flag cleared");

	a_update_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kaat_pkg::S_UPD |=> state_q == kaat_pkg::S_IDLE && !busy)
		else $error("sum update did not finish the add");

endmodule
